// ----- rtl/lcdseq_pkg.sv -----
// Shared types and constants for the character LCD nibble bus sequencer.
// No dependencies; compiled before the interfaces and the top level.
package lcdseq_pkg;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_COMMAND = 2'd1,
        OP_DATA    = 2'd2,
        OP_GOTO    = 2'd3
    } op_t;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_SETUP    = 2'd0,
        REG_ENABLE   = 2'd1,
        REG_BUSY     = 2'd2,
        REG_POWER_UP = 2'd3
    } reg_idx_t;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int HOLD_W  = 26;
    localparam int STEP_W  = 4;
    localparam int PHASE_W = 3;

    // Register reset values
    localparam logic [15:0] SETUP_RST    = 16'd500;
    localparam logic [15:0] ENABLE_RST   = 16'd1000;
    localparam logic [19:0] BUSY_RST     = 20'd200000;
    localparam logic [25:0] POWER_UP_RST = 26'd30000000;

    // Fixed init timing and codes
    localparam logic [HOLD_W-1:0] INIT_SETUP_NS = 26'd300;
    localparam logic [3:0]        MODE_NIBBLE   = 4'h2;
    localparam logic [7:0]        DISPLAY_CMD   = 8'h0C;
    localparam logic [7:0]        FUNCTION_CMD  = 8'h28;

    // Step numbering across one request; byte requests start at STEP_BYTE_B
    localparam logic [STEP_W-1:0] STEP_POWER      = 4'd0;
    localparam logic [STEP_W-1:0] STEP_MODE_SETUP = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MODE_HI    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MODE_LO    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_BYTE_A     = 4'd4;
    localparam logic [STEP_W-1:0] STEP_BYTE_B     = 4'd9;
    localparam logic [STEP_W-1:0] STEP_LAST       = 4'd13;

    // Phases of one byte transfer
    typedef enum logic [PHASE_W-1:0] {
        PH_SETUP   = 3'd0,
        PH_HI_HIGH = 3'd1,
        PH_HI_LOW  = 3'd2,
        PH_LO_HIGH = 3'd3,
        PH_LO_LOW  = 3'd4
    } phase_t;

    // DDRAM base address command for each display row
    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        unique case (row)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'hC0;
            2'd2:    base = 8'h94;
            default: base = 8'hD4;
        endcase
        return base;
    endfunction

endpackage

// ----- rtl/lcdseq_req_if.sv -----
// Request channel interface: one LCD operation per request.
// Depends on nothing; payload widths follow the request fields.
interface lcdseq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] value;
    logic [7:0] column;
    logic [7:0] row;

    modport source (output valid, operation, value, column, row, input ready);
    modport sink   (input valid, operation, value, column, row, output ready);
endinterface

// ----- rtl/lcdseq_pin_if.sv -----
// Pin state channel interface: one timed LCD pin state per request.
// Depends on nothing; payload widths follow the pin state fields.
interface lcdseq_pin_if;
    logic        valid;
    logic        ready;
    logic        reg_select;
    logic        read_write;
    logic        enable;
    logic [3:0]  bus_nibble;
    logic        pins_driven;
    logic [25:0] hold_ns;
    logic        last;

    modport source (output valid, reg_select, read_write, enable, bus_nibble,
                    pins_driven, hold_ns, last, input ready);
    modport sink   (input valid, reg_select, read_write, enable, bus_nibble,
                    pins_driven, hold_ns, last, output ready);
endinterface

// ----- rtl/char_lcd_nibble_bus_sequencer_core.sv -----
// Top level of the character LCD 4-bit bus sequencer.
// Depends on lcdseq_pkg, lcdseq_req_if and lcdseq_pin_if.
//
// Usage:
//   cmd_in carries one request per handshake: init, command byte, data byte
//   or cursor goto. pins_out carries the resulting timed pin states, one per
//   handshake, with last set on the final state of each request.
//   A byte request produces 5 pin states, init produces 14. The step counter
//   walks the pin states, one per cycle unless pins_out stalls. The next
//   request is taken in the same cycle the final state of the current one
//   is loaded into the output register, so requests run back to back with
//   no gap. Once a request is accepted, its first pin state is loaded into
//   the output register as soon as pins_out can advance.
//   When pins_out stalls, the output register holds and the step counter
//   waits; cmd_in stays not ready until the current request's final state
//   has moved into the output register.
//   The APB port sets the four timing registers (ns); write them only while
//   idle. Reset restores the default timings, clears the held bus nibble and
//   RS level, and marks the pins undriven until the first init.
module char_lcd_nibble_bus_sequencer_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lcdseq_pkg::ADDR_W-1:0]  paddr,
    input  logic [lcdseq_pkg::DATA_W-1:0]  pwdata,
    output logic [lcdseq_pkg::DATA_W-1:0]  prdata,
    output logic                           pready,
    lcdseq_req_if.sink                     cmd_in,
    lcdseq_pin_if.source                   pins_out
);
    import lcdseq_pkg::*;

    // Configuration registers
    logic [15:0] setup_reg;
    logic [15:0] enable_reg;
    logic [19:0] busy_reg;
    logic [25:0] power_up_reg;

    // Current request
    logic              cur_valid_reg;
    logic [STEP_W-1:0] step_reg;
    logic              cur_init_reg;
    logic              cur_rs_reg;
    logic [7:0]        byte_a_reg;
    logic [7:0]        byte_b_reg;

    // Bus state carried between pin states
    logic       held_select_reg;
    logic [3:0] held_nibble_reg;
    logic       outputs_enabled_reg;

    // Output register
    logic              out_valid_reg;
    logic              out_rs_reg;
    logic              out_e_reg;
    logic [3:0]        out_nib_reg;
    logic              out_driven_reg;
    logic [HOLD_W-1:0] out_hold_reg;
    logic              out_last_reg;

    logic              advance;
    logic              emit;
    logic              accept;
    logic              wr_en;
    reg_idx_t          wr_idx;

    logic [7:0]        goto_cmd;
    logic              req_init;
    logic              req_rs;
    logic [7:0]        req_byte_a;
    logic [7:0]        req_byte_b;

    logic              st_rs;
    logic              st_e;
    logic [3:0]        st_nib;
    logic [HOLD_W-1:0] st_hold;
    logic [7:0]        cur_byte;
    phase_t            phase;
    logic [HOLD_W-1:0] hold_setup;
    logic [HOLD_W-1:0] hold_enable;
    logic [HOLD_W-1:0] hold_final;

    // APB port
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign wr_idx = reg_idx_t'(paddr[3:2]);

    always_comb
    begin
        unique case (wr_idx)
            REG_SETUP:    prdata = {16'd0, setup_reg};
            REG_ENABLE:   prdata = {16'd0, enable_reg};
            REG_BUSY:     prdata = {12'd0, busy_reg};
            REG_POWER_UP: prdata = {6'd0, power_up_reg};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setup_reg    <= SETUP_RST;
            enable_reg   <= ENABLE_RST;
            busy_reg     <= BUSY_RST;
            power_up_reg <= POWER_UP_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_SETUP:    setup_reg    <= pwdata[15:0];
                REG_ENABLE:   enable_reg   <= pwdata[15:0];
                REG_BUSY:     busy_reg     <= pwdata[19:0];
                REG_POWER_UP: power_up_reg <= pwdata[25:0];
                default:      ;
            endcase
        end
    end

    // Handshake control
    assign advance      = !out_valid_reg || pins_out.ready;
    assign emit         = cur_valid_reg && advance;
    assign cmd_in.ready = !cur_valid_reg || (emit && step_reg == STEP_LAST);
    assign accept       = cmd_in.valid && cmd_in.ready;

    // Request decode: init sends the display command ORed with the value, then the function command; others one byte
    assign goto_cmd = (cmd_in.row[7:2] == 6'd0)
                    ? 8'(row_base(cmd_in.row[1:0]) + cmd_in.column)
                    : cmd_in.column;

    always_comb
    begin
        req_init   = 1'b0;
        req_rs     = 1'b0;
        req_byte_a = DISPLAY_CMD | cmd_in.value;
        req_byte_b = cmd_in.value;
        unique case (op_t'(cmd_in.operation))
            OP_INIT:
            begin
                req_init   = 1'b1;
                req_byte_b = FUNCTION_CMD;
            end
            OP_COMMAND: req_byte_b = cmd_in.value;
            OP_DATA:    req_rs     = 1'b1;
            OP_GOTO:    req_byte_b = goto_cmd;
            default:    ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            step_reg      <= STEP_POWER;
        end
        else if (accept)
        begin
            cur_valid_reg <= 1'b1;
            step_reg      <= req_init ? STEP_POWER : STEP_BYTE_B;
        end
        else if (emit)
        begin
            if (step_reg == STEP_LAST)
                cur_valid_reg <= 1'b0;
            else
                step_reg <= step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur_init_reg <= req_init;
            cur_rs_reg   <= req_rs;
            byte_a_reg   <= req_byte_a;
            byte_b_reg   <= req_byte_b;
        end
    end

    // Pin state for the current step
    assign hold_setup  = HOLD_W'(setup_reg);
    assign hold_enable = HOLD_W'(enable_reg);
    assign hold_final  = HOLD_W'(enable_reg) + HOLD_W'(busy_reg);

    always_comb
    begin
        if (step_reg >= STEP_BYTE_B)
        begin
            phase    = phase_t'(PHASE_W'(step_reg - STEP_BYTE_B));
            cur_byte = byte_b_reg;
        end
        else
        begin
            phase    = phase_t'(PHASE_W'(step_reg - STEP_BYTE_A));
            cur_byte = byte_a_reg;
        end
    end

    always_comb
    begin
        st_rs   = cur_rs_reg;
        st_e    = 1'b0;
        st_nib  = held_nibble_reg;
        st_hold = hold_setup;
        priority if (step_reg == STEP_POWER)
        begin
            st_rs   = held_select_reg;
            st_hold = power_up_reg;
        end
        else if (step_reg == STEP_MODE_SETUP)
        begin
            st_rs   = 1'b0;
            st_nib  = 4'h0;
            st_hold = INIT_SETUP_NS;
        end
        else if (step_reg == STEP_MODE_HI)
        begin
            st_rs   = 1'b0;
            st_e    = 1'b1;
            st_nib  = MODE_NIBBLE;
            st_hold = hold_enable;
        end
        else if (step_reg == STEP_MODE_LO)
        begin
            st_rs   = 1'b0;
            st_nib  = MODE_NIBBLE;
            st_hold = hold_final;
        end
        else
        begin
            unique case (phase)
                PH_SETUP:
                begin
                    st_nib  = held_nibble_reg;
                    st_hold = hold_setup;
                end
                PH_HI_HIGH:
                begin
                    st_e    = 1'b1;
                    st_nib  = cur_byte[7:4];
                    st_hold = hold_enable;
                end
                PH_HI_LOW:
                begin
                    st_nib  = cur_byte[7:4];
                    st_hold = hold_enable;
                end
                PH_LO_HIGH:
                begin
                    st_e    = 1'b1;
                    st_nib  = cur_byte[3:0];
                    st_hold = hold_enable;
                end
                PH_LO_LOW:
                begin
                    st_nib  = cur_byte[3:0];
                    st_hold = hold_final;
                end
                default: ;
            endcase
        end
    end

    // Held bus levels follow the last pin state sent; init enables outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_select_reg     <= 1'b0;
            held_nibble_reg     <= 4'h0;
            outputs_enabled_reg <= 1'b0;
        end
        else if (emit)
        begin
            held_select_reg <= st_rs;
            held_nibble_reg <= st_nib;
            if (cur_init_reg && step_reg == STEP_POWER)
                outputs_enabled_reg <= 1'b1;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= cur_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_rs_reg     <= st_rs;
            out_e_reg      <= st_e;
            out_nib_reg    <= st_nib;
            out_driven_reg <= outputs_enabled_reg;
            out_hold_reg   <= st_hold;
            out_last_reg   <= (step_reg == STEP_LAST);
        end
    end

    assign pins_out.valid       = out_valid_reg;
    assign pins_out.reg_select  = out_rs_reg;
    assign pins_out.read_write  = 1'b0;
    assign pins_out.enable      = out_e_reg;
    assign pins_out.bus_nibble  = out_nib_reg;
    assign pins_out.pins_driven = out_driven_reg;
    assign pins_out.hold_ns     = out_hold_reg;
    assign pins_out.last        = out_last_reg;

    // Checks
    a_last_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        emit && step_reg == STEP_LAST |=> out_valid_reg && out_last_reg)
        else $error("final step did not produce a last pin state");

    a_init_enables: assert property (@(posedge clk) disable iff (!rst_n)
        emit && cur_init_reg && step_reg == STEP_POWER |=> outputs_enabled_reg)
        else $error("init did not enable the outputs");

    a_last_enable_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_last_reg |-> !out_e_reg)
        else $error("request ended with enable high");

    a_no_accept_midway: assert property (@(posedge clk) disable iff (!rst_n)
        accept && cur_valid_reg |-> emit && step_reg == STEP_LAST)
        else $error("request accepted while another was in progress");

endmodule

// ----- sim/tb_top.sv -----
// Self-checking testbench for char_lcd_nibble_bus_sequencer_core.
// Depends on lcdseq_pkg, lcdseq_req_if, lcdseq_pin_if and the core itself.
// Predicts each timed pin state and checks it in order against pins_out.
module tb_top;
    import lcdseq_pkg::*;

    // Expected pin state, one per pins_out request
    typedef struct packed {
        logic              reg_select;
        logic              read_write;
        logic              enable;
        logic [3:0]        bus_nibble;
        logic              pins_driven;
        logic [HOLD_W-1:0] hold_ns;
        logic              last;
    } pin_state_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    lcdseq_req_if req_if ();
    lcdseq_pin_if pins_if ();

    char_lcd_nibble_bus_sequencer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .cmd_in   (req_if.sink),
        .pins_out (pins_if.source)
    );

    // Predictor copy of timing registers and bus state
    logic [15:0]       setup_ns;
    logic [15:0]       enable_ns;
    logic [19:0]       busy_ns;
    logic [25:0]       power_up_ns;
    logic [3:0]        bus_nibble_now;
    logic              rs_now;
    logic              pins_live;

    pin_state_t        expected_pins[$];
    pin_state_t        head_pin;

    int                errors;
    int                sent_requests;
    int                init_requests;
    int                checked_pins;
    int                reg_writes;
    bit                steady_run;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit, far above the slowest legal run
    initial
    begin
        #2000000;
        $display("%0t: timeout, %0d pin states still pending", $time, expected_pins.size());
        $display("Verification failed");
        $finish;
    end

    // Receiver backpressure
    always @(negedge clk)
    begin
        pins_if.ready <= steady_run || ($urandom_range(0, 99) >= 29);
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void push_pin(logic rs, logic en, logic [3:0] nib,
                                     logic [HOLD_W-1:0] hold, logic last);
        pin_state_t p;
        p.reg_select  = rs;
        p.read_write  = 1'b0;
        p.enable      = en;
        p.bus_nibble  = nib;
        p.pins_driven = pins_live;
        p.hold_ns     = hold;
        p.last        = last;
        expected_pins.push_back(p);
    endfunction

    // Setup, then two enable pulses: high nibble, low nibble plus busy wait
    function automatic void queue_byte_states(logic [7:0] c, logic rs, logic last);
        logic [HOLD_W-1:0] en_hold;
        logic [HOLD_W-1:0] tail_hold;
        en_hold   = HOLD_W'(enable_ns);
        tail_hold = HOLD_W'(enable_ns) + HOLD_W'(busy_ns);
        push_pin(rs, 1'b0, bus_nibble_now, HOLD_W'(setup_ns), 1'b0);
        push_pin(rs, 1'b1, c[7:4], en_hold, 1'b0);
        push_pin(rs, 1'b0, c[7:4], en_hold, 1'b0);
        push_pin(rs, 1'b1, c[3:0], en_hold, 1'b0);
        push_pin(rs, 1'b0, c[3:0], tail_hold, last);
        bus_nibble_now = c[3:0];
        rs_now         = rs;
    endfunction

    function automatic void predict_pin_states(op_t op, logic [7:0] value,
                                               logic [7:0] column, logic [7:0] row);
        logic [7:0] cmd;
        case (op)
            OP_INIT:
            begin
                // power-up wait shows the old pins and the old drive state
                push_pin(rs_now, 1'b0, bus_nibble_now, power_up_ns, 1'b0);
                pins_live      = 1'b1;
                bus_nibble_now = 4'h0;
                rs_now         = 1'b0;
                push_pin(1'b0, 1'b0, 4'h0, INIT_SETUP_NS, 1'b0);
                push_pin(1'b0, 1'b1, MODE_NIBBLE, HOLD_W'(enable_ns), 1'b0);
                push_pin(1'b0, 1'b0, MODE_NIBBLE,
                         HOLD_W'(enable_ns) + HOLD_W'(busy_ns), 1'b0);
                bus_nibble_now = MODE_NIBBLE;
                queue_byte_states(DISPLAY_CMD | value, 1'b0, 1'b0);
                queue_byte_states(FUNCTION_CMD, 1'b0, 1'b1);
            end
            OP_COMMAND: queue_byte_states(value, 1'b0, 1'b1);
            OP_DATA:    queue_byte_states(value, 1'b1, 1'b1);
            default:
            begin
                // rows past 3 send the bare column
                case (row)
                    8'd0:    cmd = 8'h80 + column;
                    8'd1:    cmd = 8'hC0 + column;
                    8'd2:    cmd = 8'h94 + column;
                    8'd3:    cmd = 8'hD4 + column;
                    default: cmd = column;
                endcase
                queue_byte_states(cmd, 1'b0, 1'b1);
            end
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Result checker
    // ---------------------------------------------------------------
    function automatic void check_field(string name, logic [HOLD_W-1:0] want,
                                        logic [HOLD_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: pin state %0d, %s expected %0h got %0h",
                     $time, checked_pins, name, want, got);
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && pins_if.valid === 1'b1 && pins_if.ready === 1'b1)
        begin
            if (expected_pins.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected pin state, expected none got rs=%0b e=%0b nib=%0h hold=%0d",
                         $time, pins_if.reg_select, pins_if.enable,
                         pins_if.bus_nibble, pins_if.hold_ns);
            end
            else
            begin
                head_pin = expected_pins.pop_front();
                check_field("reg_select", HOLD_W'(head_pin.reg_select),
                            HOLD_W'(pins_if.reg_select));
                check_field("read_write", HOLD_W'(head_pin.read_write),
                            HOLD_W'(pins_if.read_write));
                check_field("enable", HOLD_W'(head_pin.enable), HOLD_W'(pins_if.enable));
                check_field("bus_nibble", HOLD_W'(head_pin.bus_nibble),
                            HOLD_W'(pins_if.bus_nibble));
                check_field("pins_driven", HOLD_W'(head_pin.pins_driven),
                            HOLD_W'(pins_if.pins_driven));
                check_field("hold_ns", head_pin.hold_ns, pins_if.hold_ns);
                check_field("last", HOLD_W'(head_pin.last), HOLD_W'(pins_if.last));
            end
            checked_pins++;
        end
    end

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Entered just after a rising edge; leaves valid high after acceptance
    task automatic send_request(op_t op, logic [7:0] value, logic [7:0] column,
                                logic [7:0] row);
        @(negedge clk);
        if (!steady_run)
        begin
            while ($urandom_range(0, 99) < 29)
            begin
                req_if.valid <= 1'b0;
                @(negedge clk);
            end
        end
        req_if.valid     <= 1'b1;
        req_if.operation <= op;
        req_if.value     <= value;
        req_if.column    <= column;
        req_if.row       <= row;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        predict_pin_states(op, value, column, row);
        sent_requests++;
        if (op == OP_INIT)
            init_requests++;
    endtask

    // Drop valid and let every pending pin state drain
    task automatic wait_idle();
        @(negedge clk);
        req_if.valid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(reg_idx_t idx, logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        case (idx)
            REG_SETUP:  setup_ns    = data[15:0];
            REG_ENABLE: enable_ns   = data[15:0];
            REG_BUSY:   busy_ns     = data[19:0];
            default:    power_up_ns = data[25:0];
        endcase
        reg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_register(reg_idx_t idx);
        logic [DATA_W-1:0] want;
        logic [DATA_W-1:0] got;
        case (idx)
            REG_SETUP:  want = DATA_W'(setup_ns);
            REG_ENABLE: want = DATA_W'(enable_ns);
            REG_BUSY:   want = DATA_W'(busy_ns);
            default:    want = DATA_W'(power_up_ns);
        endcase
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (pready !== 1'b1)
            @(posedge clk);
        got = prdata;
        if (got !== want)
        begin
            errors++;
            $display("%0t: register %s read expected %0h got %0h",
                     $time, idx.name(), want, got);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write all four timings while idle, then read them back
    task automatic set_timing(logic [15:0] s, logic [15:0] e, logic [19:0] b,
                              logic [25:0] p);
        wait_idle();
        write_register(REG_SETUP, DATA_W'(s));
        write_register(REG_ENABLE, DATA_W'(e));
        write_register(REG_BUSY, DATA_W'(b));
        write_register(REG_POWER_UP, DATA_W'(p));
        check_register(REG_SETUP);
        check_register(REG_ENABLE);
        check_register(REG_BUSY);
        check_register(REG_POWER_UP);
    endtask

    // Mostly byte and goto requests, some inits, rows mostly in range
    task automatic run_random(int count);
        op_t        op;
        int         pick;
        logic [7:0] row;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                op = OP_INIT;
            else if (pick < 40)
                op = OP_COMMAND;
            else if (pick < 70)
                op = OP_DATA;
            else
                op = OP_GOTO;
            if ($urandom_range(0, 3) == 0)
                row = 8'($urandom_range(0, 255));
            else
                row = 8'($urandom_range(0, 3));
            send_request(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), row);
        end
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_register_defaults();
        check_register(REG_SETUP);
        check_register(REG_ENABLE);
        check_register(REG_BUSY);
        check_register(REG_POWER_UP);
    endtask

    task automatic test_directed_requests();
        // bytes before any init go out with pins undriven
        send_request(OP_COMMAND, 8'h00, 8'h00, 8'h00);
        send_request(OP_DATA, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_GOTO, 8'h00, 8'h12, 8'h01);
        // first init, then a repeated one with the pins already driven
        send_request(OP_INIT, 8'h00, 8'h00, 8'h00);
        send_request(OP_INIT, 8'hFF, 8'hFF, 8'hFF);
        send_request(OP_COMMAND, 8'hFF, 8'h00, 8'h00);
        send_request(OP_COMMAND, 8'h01, 8'h00, 8'h00);
        send_request(OP_DATA, 8'hA5, 8'h00, 8'h00);
        send_request(OP_DATA, 8'h5A, 8'h00, 8'h00);
        send_request(OP_DATA, 8'h00, 8'h00, 8'h00);
        // each row base, with column wrap past 0xFF
        send_request(OP_GOTO, 8'h00, 8'h00, 8'h00);
        send_request(OP_GOTO, 8'h00, 8'h3F, 8'h01);
        send_request(OP_GOTO, 8'h00, 8'hFF, 8'h02);
        send_request(OP_GOTO, 8'h00, 8'h2C, 8'h03);
        send_request(OP_GOTO, 8'h00, 8'hFF, 8'h00);
        // rows out of range send the column alone
        send_request(OP_GOTO, 8'h00, 8'h55, 8'h04);
        send_request(OP_GOTO, 8'h00, 8'hAA, 8'hFF);
        send_request(OP_GOTO, 8'h00, 8'h00, 8'h80);
        send_request(OP_INIT, 8'h03, 8'h00, 8'h00);
        wait_idle();
    endtask

    task automatic test_timing_extremes();
        set_timing(16'h0000, 16'h0000, 20'h00000, 26'h0000000);
        run_random(60);
        set_timing(16'hFFFF, 16'hFFFF, 20'hFFFFF, 26'h3FFFFFF);
        run_random(60);
        wait_idle();
    endtask

    task automatic test_back_to_back();
        set_timing(SETUP_RST, ENABLE_RST, BUSY_RST, POWER_UP_RST);
        steady_run = 1'b1;
        run_random(100);
        wait_idle();
        steady_run = 1'b0;
    endtask

    task automatic test_drain_pause();
        run_random(40);
        wait_idle();
        run_random(40);
        wait_idle();
    endtask

    task automatic test_random_timing();
        repeat (3)
        begin
            set_timing(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       20'($urandom_range(0, 1048575)), 26'($urandom));
            run_random(35);
        end
        wait_idle();
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial
    begin
        rst_n            = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_if.valid     = 1'b0;
        req_if.operation = OP_INIT;
        req_if.value     = 8'h00;
        req_if.column    = 8'h00;
        req_if.row       = 8'h00;
        pins_if.ready    = 1'b0;
        steady_run       = 1'b0;
        errors           = 0;
        sent_requests    = 0;
        init_requests    = 0;
        checked_pins     = 0;
        reg_writes       = 0;
        setup_ns         = SETUP_RST;
        enable_ns        = ENABLE_RST;
        busy_ns          = BUSY_RST;
        power_up_ns      = POWER_UP_RST;
        bus_nibble_now   = 4'h0;
        rs_now           = 1'b0;
        pins_live        = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_defaults();
        test_directed_requests();
        test_timing_extremes();
        test_back_to_back();
        test_drain_pause();
        test_random_timing();

        wait_idle();
        repeat (20) @(posedge clk);

        $display("Covered %0d requests (%0d inits) and %0d pin states over %0d register writes,",
                 sent_requests, init_requests, checked_pins, reg_writes);
        $display("including zero and full-scale timings, bytes before init and row wrap.");
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ----- char_lcd_nibble_bus_sequencer_core.f -----
rtl/lcdseq_pkg.sv
rtl/lcdseq_req_if.sv
rtl/lcdseq_pin_if.sv
rtl/char_lcd_nibble_bus_sequencer_core.sv
sim/tb_top.sv
